>>> hw/rtl/fbc_pkg.sv
// Shared types, constants and helpers for the frustum box cull block.
package fbc_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;
  localparam int LANES       = 4;
  localparam int LANE_W      = 16;
  localparam int COORD_W     = 16;
  localparam int COEF_W      = LANE_W + 1;
  localparam int PROD_W      = COEF_W + COORD_W;
  localparam int DIST_W      = PROD_W + 3;
  localparam int ROW_W       = LANES * LANE_W;
  localparam int ADDR_W      = 5;
  localparam int REG_SEL_W   = 2;

  // Register indexes (byte address = 8 * index)
  localparam logic [REG_SEL_W-1:0] REG_ROW_ZERO  = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_ROW_ONE   = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_ROW_TWO   = 2'd2;
  localparam logic [REG_SEL_W-1:0] REG_ROW_THREE = 2'd3;

  // Reset rows: identity matrix in Q7.8
  localparam logic [ROW_W-1:0] ROW_ZERO_RST  = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW_ONE_RST   = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW_TWO_RST   = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW_THREE_RST = 64'h0100_0000_0000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic s1_en;  // load the product stage
    logic s2_en;  // load the distance sign stage
  } pipe_ctl_t;

  // Coefficient k of a plane: row three plus or minus the selected row
  function automatic coef_t plane_coef(input logic [ROW_W-1:0] r3,
                                       input logic [ROW_W-1:0] rk,
                                       input logic             minus,
                                       input int unsigned      k);
    coef_t a;
    coef_t b;
    a = coef_t'($signed(r3[LANE_W*k +: LANE_W]));
    b = coef_t'($signed(rk[LANE_W*k +: LANE_W]));
    return minus ? coef_t'(a - b) : coef_t'(a + b);
  endfunction

endpackage

>>> hw/rtl/fbc_if.sv
// Stream interfaces for box beats in and visibility beats out.
interface fbc_box_if;
  import fbc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (output valid, output box_min_x, output box_min_y, output box_min_z,
                  output box_max_x, output box_max_y, output box_max_z, input ready);
  modport sink   (input valid, input box_min_x, input box_min_y, input box_min_z,
                  input box_max_x, input box_max_y, input box_max_z, output ready);
endinterface

interface fbc_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, output visible, input ready);
  modport sink   (input valid, input visible, output ready);
endinterface

>>> hw/rtl/frustum_box_cull.sv
// Frustum box cull top level: APB matrix registers and a four-stage cull pipeline.
// Throughput: one box per cycle while out_ch is ready; each stage holds only while the one after it is full.
// Stages: input register, corner select and multiply, distance sign, output register.
// Reset (rst_n low, synchronous): clear all valid bits, load the identity matrix.
// Coefficients follow the matrix registers in the next cycle, registered ahead of the multiply stage.
module frustum_box_cull (
  input  logic                          clk,
  input  logic                          rst_n,
  fbc_box_if.sink                       in_ch,
  fbc_vis_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbc_pkg::ADDR_W-1:0]    paddr,
  input  logic [fbc_pkg::ROW_W-1:0]     pwdata,
  output logic [fbc_pkg::ROW_W-1:0]     prdata,
  output logic                          pready
);
  import fbc_pkg::*;

  // ---------------------------------------------------------------------
  // Matrix registers
  // ---------------------------------------------------------------------
  logic [ROW_W-1:0]     row_r [LANES];
  logic                 wr_en;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ADDR_W-1 -: REG_SEL_W];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[REG_ROW_ZERO]  <= ROW_ZERO_RST;
      row_r[REG_ROW_ONE]   <= ROW_ONE_RST;
      row_r[REG_ROW_TWO]   <= ROW_TWO_RST;
      row_r[REG_ROW_THREE] <= ROW_THREE_RST;
    end else if (wr_en) begin
      row_r[reg_sel] <= pwdata;
    end
  end

  // Read back the addressed row
  always_comb begin
    unique case (reg_sel)
      REG_ROW_ZERO:  prdata = row_r[REG_ROW_ZERO];
      REG_ROW_ONE:   prdata = row_r[REG_ROW_ONE];
      REG_ROW_TWO:   prdata = row_r[REG_ROW_TWO];
      REG_ROW_THREE: prdata = row_r[REG_ROW_THREE];
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Plane coefficients: plane p uses row p/2, minus on odd p.
  // Registered so the add does not sit in front of the multipliers.
  // ---------------------------------------------------------------------
  coef_t [LANES-1:0] coef_r   [PLANE_COUNT];
  coef_t [LANES-1:0] coef_nxt [PLANE_COUNT];

  always_comb begin
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int k = 0; k < LANES; k++) begin
        coef_nxt[p][k] = plane_coef(row_r[REG_ROW_THREE], row_r[p / 2],
                                    1'(p % 2), k);
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  // ---------------------------------------------------------------------
  // Pipeline control: each stage advances when it is empty or the next
  // stage advances, so bubbles squeeze out under an output stall.
  // ---------------------------------------------------------------------
  logic      v0_r, v1_r, v2_r, v3_r;
  logic      rdy0, rdy1, rdy2, rdy3;
  pipe_ctl_t ctl;

  assign rdy3 = !v3_r || out_ch.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign rdy0 = !v0_r || rdy1;

  assign in_ch.ready = rdy0;
  assign ctl.s1_en   = rdy1;
  assign ctl.s2_en   = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_ch.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture the box beat
  // ---------------------------------------------------------------------
  box_t box_r;

  always_ff @(posedge clk) begin
    if (rdy0) begin
      box_r.min_x <= in_ch.box_min_x;
      box_r.min_y <= in_ch.box_min_y;
      box_r.min_z <= in_ch.box_min_z;
      box_r.max_x <= in_ch.box_max_x;
      box_r.max_y <= in_ch.box_max_y;
      box_r.max_z <= in_ch.box_max_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 1 and 2: one unit per plane
  // ---------------------------------------------------------------------
  logic [PLANE_COUNT-1:0] neg;

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    fbc_plane u_plane (
      .clk   (clk),
      .ctl   (ctl),
      .coef  (coef_r[p]),
      .box   (box_r),
      .neg_r (neg[p])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 3: output register; mark the box not visible if any plane sees it behind
  // ---------------------------------------------------------------------
  logic visible_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      visible_r <= ~|neg;
    end
  end

  assign out_ch.valid   = v3_r;
  assign out_ch.visible = visible_r;

endmodule

>>> hw/rtl/fbc_plane.sv
// One frustum plane: corner select and products, then distance sign.
module fbc_plane (
  input  logic                              clk,
  input  fbc_pkg::pipe_ctl_t                ctl,
  input  fbc_pkg::coef_t [fbc_pkg::LANES-1:0] coef,
  input  fbc_pkg::box_t                     box,
  output logic                              neg_r
);
  import fbc_pkg::*;

  coord_t lo [AXES];
  coord_t hi [AXES];
  prod_t  prod_r   [AXES];
  prod_t  prod_nxt [AXES];
  dist_t  dist_sum;
  logic   neg_nxt;

  assign lo[0] = box.min_x;
  assign lo[1] = box.min_y;
  assign lo[2] = box.min_z;
  assign hi[0] = box.max_x;
  assign hi[1] = box.max_y;
  assign hi[2] = box.max_z;

  // Positive corner: max where the normal component is non-negative
  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      prod_nxt[k] = coef[k] * (coef[k][COEF_W-1] ? lo[k] : hi[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_en) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    dist_sum = dist_t'(prod_r[0]) + dist_t'(prod_r[1]) + dist_t'(prod_r[2])
             + dist_t'(coef[LANES-1]);
    neg_nxt = dist_sum[DIST_W-1];
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_en) begin
      neg_r <= neg_nxt;
    end
  end

endmodule

>>> hw/rtl/fbc_checker.sv
// Port-level checks for the frustum box cull block, bound to the top level.
module fbc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible,
  input logic pready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("stalled result beat changed or dropped");

  // An empty output register means every stage can advance
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  // Reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A beat taken with the output draining reaches out_valid through every stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result beat missing after pipeline latency");

  // Configuration port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_visible (out_ch.visible),
  .pready      (pready)
);

>>> verif/frustum_box_cull_tb.sv
// Self-checking testbench for the frustum box cull block: directed and random box streams.
module frustum_box_cull_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbc_pkg::*;

  // Pipeline depth from an accepted box beat to its visibility beat.
  localparam int LATENCY      = 4;
  // Coefficients are registered behind the matrix registers; give the pipe a little extra.
  localparam int SETTLE       = 2 * LATENCY;
  localparam int MAX_CYCLES   = 200000;
  localparam int REPORT_LIMIT = 10;
  // Random beats per matrix setting; two settings per idling phase.
  localparam int HALF_PHASE   = 48;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [ROW_W-1:0]  pwdata;
  logic [ROW_W-1:0]  prdata;
  logic              pready;

  fbc_box_if box_ch ();
  fbc_vis_if vis_ch ();

  frustum_box_cull dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (box_ch),
    .out_ch  (vis_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the matrix registers, indexed by register index.
  logic [ROW_W-1:0] matrix_rows [LANES];
  // Row paired with row three for each plane pair (plus and minus).
  localparam logic [REG_SEL_W-1:0] PLANE_ROW [AXES] = '{REG_ROW_ZERO, REG_ROW_ONE, REG_ROW_TWO};

  // Visibility verdicts of accepted boxes, oldest first.
  logic expected_visible_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int error_count;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles; end the run as failed if the limit is ever reached.
  initial begin
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Visibility predictor
  // ---------------------------------------------------------------------------
  function automatic longint lane_value(input logic [ROW_W-1:0] row, input int k);
    logic signed [LANE_W-1:0] v;
    v = row[LANE_W*k +: LANE_W];
    return v;
  endfunction

  // Test the box against all six planes: row three plus and minus rows zero to two.
  // The corner on each axis is max where the normal component is >= 0, else min.
  // Everything is exact in 64 bits; a distance of exactly zero keeps the box.
  function automatic logic box_in_frustum(input box_t b);
    longint lo [AXES];
    longint hi [AXES];
    longint coef [LANES];
    longint plane_dist;
    logic [ROW_W-1:0] pair_row;
    logic seen;
    lo[0] = b.min_x;
    lo[1] = b.min_y;
    lo[2] = b.min_z;
    hi[0] = b.max_x;
    hi[1] = b.max_y;
    hi[2] = b.max_z;
    seen = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      pair_row = matrix_rows[PLANE_ROW[p / 2]];
      for (int k = 0; k < LANES; k++) begin
        if (p % 2 == 1) begin
          coef[k] = lane_value(matrix_rows[REG_ROW_THREE], k) - lane_value(pair_row, k);
        end else begin
          coef[k] = lane_value(matrix_rows[REG_ROW_THREE], k) + lane_value(pair_row, k);
        end
      end
      plane_dist = coef[LANES-1];
      for (int k = 0; k < AXES; k++) begin
        plane_dist += coef[k] * ((coef[k] >= 0) ? hi[k] : lo[k]);
      end
      if (plane_dist < 0) seen = 1'b0;
    end
    return seen;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and compare each visibility beat in order
  // ---------------------------------------------------------------------------
  initial begin
    vis_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      vis_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic flag_error(input string what, input logic want, input logic got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("%0t ns: %s: expected visible=%b, actual visible=%b", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : check_visibility
    logic want;
    if (rst_n && vis_ch.valid && vis_ch.ready) begin
      if (expected_visible_q.size() == 0) begin
        flag_error("visibility beat with no box pending", 1'bx, vis_ch.visible);
      end else begin
        want = expected_visible_q.pop_front();
        if (vis_ch.visible !== want) flag_error("visible mismatch", want, vis_ch.visible);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Box side and register port
  // ---------------------------------------------------------------------------

  // Drive one box beat; idle at random first; record its verdict on acceptance.
  task automatic send_box(input box_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(negedge clk);
    end
    box_ch.valid     <= 1'b1;
    box_ch.box_min_x <= b.min_x;
    box_ch.box_min_y <= b.min_y;
    box_ch.box_min_z <= b.min_z;
    box_ch.box_max_x <= b.max_x;
    box_ch.box_max_y <= b.max_y;
    box_ch.box_max_z <= b.max_z;
    @(posedge clk);
    while (!box_ch.ready) @(posedge clk);
    expected_visible_q.push_back(box_in_frustum(b));
  endtask

  // Drop valid, hold until every verdict is back, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk);
    box_ch.valid <= 1'b0;
    while (expected_visible_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // APB write: setup cycle, then access; the register takes it when pready is high.
  task automatic write_row(input logic [REG_SEL_W-1:0] idx, input logic [ROW_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 3'b000});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    matrix_rows[idx] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Load all four rows while idle, then wait for the coefficients to follow.
  task automatic load_matrix(input logic [ROW_W-1:0] r0, input logic [ROW_W-1:0] r1,
                             input logic [ROW_W-1:0] r2, input logic [ROW_W-1:0] r3);
    write_row(REG_ROW_ZERO, r0);
    write_row(REG_ROW_ONE, r1);
    write_row(REG_ROW_TWO, r2);
    write_row(REG_ROW_THREE, r3);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [ROW_W-1:0] pack_row(input int x, input int y, input int z,
                                                 input int w);
    return {w[LANE_W-1:0], z[LANE_W-1:0], y[LANE_W-1:0], x[LANE_W-1:0]};
  endfunction

  function automatic box_t make_box(input int x0, input int y0, input int z0,
                                    input int x1, input int y1, input int z1);
    box_t b;
    b.min_x = coord_t'(x0);
    b.min_y = coord_t'(y0);
    b.min_z = coord_t'(z0);
    b.max_x = coord_t'(x1);
    b.max_y = coord_t'(y1);
    b.max_z = coord_t'(z1);
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset matrix is the identity: the frustum is the cube [-1, 1] on every axis.
  task automatic test_identity_edges();
    send_box(make_box(-1, -1, -1, 1, 1, 1));
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    // Touch a face exactly: distance zero keeps the box; one unit further culls it.
    send_box(make_box(-100, -5, -5, -1, 5, 5));
    send_box(make_box(-100, -5, -5, -2, 5, 5));
    send_box(make_box(-5, 1, -5, 5, 100, 5));
    send_box(make_box(-5, 2, -5, 5, 100, 5));
    send_box(make_box(-5, -5, -100, 5, 5, -1));
    send_box(make_box(-5, -5, -100, 5, 5, -2));
    // Inverted boxes: corner selection runs as usual with min above max.
    send_box(make_box(1, 1, 1, -1, -1, -1));
    send_box(make_box(5, 5, 5, -5, -5, -5));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
  endtask

  // Planes whose normal is all zero are decided by d alone.
  task automatic test_zero_normal();
    wait_drained();
    // Row zero equal to row three: the minus-x plane is all zero and keeps every box.
    load_matrix(pack_row(0, 0, 0, 256), ROW_ONE_RST, ROW_TWO_RST, ROW_THREE_RST);
    send_box(make_box(30000, 0, 0, 30000, 0, 0));
    send_box(make_box(30000, 5, 0, 30000, 5, 0));
    // d of the minus-x plane drops to -1.0: it rejects every box.
    wait_drained();
    load_matrix(pack_row(0, 0, 0, 512), ROW_ONE_RST, ROW_TWO_RST, ROW_THREE_RST);
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
  endtask

  // Lane extremes give the widest coefficients, products and sums.
  task automatic test_matrix_extremes();
    logic [ROW_W-1:0] neg_row;
    logic [ROW_W-1:0] pos_row;
    neg_row = pack_row(-32768, -32768, -32768, -32768);
    pos_row = pack_row(32767, 32767, 32767, 32767);
    wait_drained();
    load_matrix(neg_row, neg_row, neg_row, neg_row);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    send_box(make_box(32767, 32767, 32767, -32768, -32768, -32768));
    wait_drained();
    load_matrix(neg_row, neg_row, neg_row, pos_row);
    send_box(make_box(-32768, -32768, -32768, -32768, -32768, -32768));
    send_box(make_box(32767, 32767, 32767, 32767, 32767, 32767));
    wait_drained();
    load_matrix(pos_row, pos_row, pos_row, neg_row);
    send_box(make_box(-32768, -32768, -32768, 32767, 32767, 32767));
    wait_drained();
    // All zero: every plane is zero with d zero, so every box is kept.
    load_matrix('0, '0, '0, '0);
    send_box(make_box(32767, -32768, 32767, -32768, 32767, -32768));
  endtask

  // A quarter of settings are fully random; the rest are a perturbed identity
  // with a random w so the frustum is a box of a few dozen units.
  task automatic load_random_matrix();
    logic [ROW_W-1:0] rows [LANES];
    int v;
    if ($urandom_range(3) == 0) begin
      for (int r = 0; r < LANES; r++) rows[r] = {$urandom, $urandom};
    end else begin
      for (int r = 0; r < LANES; r++) begin
        for (int k = 0; k < LANES; k++) begin
          v = int'($urandom_range(128)) - 64;
          if (r == k && r < AXES) v += 256;
          if (r == LANES - 1 && k == LANES - 1) v = int'($urandom_range(16384, 256));
          rows[r][LANE_W*k +: LANE_W] = v[LANE_W-1:0];
        end
      end
    end
    load_matrix(rows[REG_ROW_ZERO], rows[REG_ROW_ONE], rows[REG_ROW_TWO], rows[REG_ROW_THREE]);
  endtask

  // Mostly boxes near the frustum; a third fully random for every bit and inversions.
  function automatic box_t random_box();
    box_t b;
    int lo [AXES];
    int hi [AXES];
    int c;
    int h;
    if ($urandom_range(2) == 0) begin
      b = {$urandom, $urandom, $urandom};
    end else begin
      for (int a = 0; a < AXES; a++) begin
        c = int'($urandom_range(192)) - 96;
        h = int'($urandom_range(48));
        lo[a] = c - h;
        hi[a] = c + h;
      end
      b = make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    end
    return b;
  endfunction

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    wait_drained();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int half = 0; half < 2; half++) begin
      // Hold off the sender until all verdicts are in, then change the matrix.
      wait_drained();
      load_random_matrix();
      repeat (HALF_PHASE) send_box(random_box());
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(0, 0);
    run_random_phase(78, 0);
    run_random_phase(0, 78);
    run_random_phase(12, 12);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    box_ch.valid     = 1'b0;
    box_ch.box_min_x = '0;
    box_ch.box_min_y = '0;
    box_ch.box_min_z = '0;
    box_ch.box_max_x = '0;
    box_ch.box_max_y = '0;
    box_ch.box_max_z = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    error_count      = 0;
    matrix_rows[REG_ROW_ZERO]  = ROW_ZERO_RST;
    matrix_rows[REG_ROW_ONE]   = ROW_ONE_RST;
    matrix_rows[REG_ROW_TWO]   = ROW_TWO_RST;
    matrix_rows[REG_ROW_THREE] = ROW_THREE_RST;

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_identity_edges();
    test_zero_normal();
    test_matrix_extremes();
    test_random_phases();

    // Drain the last verdicts and give the pipe time to show any stray beat.
    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fbc_pkg.sv
hw/rtl/fbc_if.sv
hw/rtl/fbc_plane.sv
hw/rtl/frustum_box_cull.sv
hw/rtl/fbc_checker.sv
verif/frustum_box_cull_tb.sv
